// ----- hw/rtl/double_ended_queue_macros.svh -----
// Assertion macros for the deque RTL, included by double_ended_queue.sv.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/deq_pkg.sv -----
`timescale 1ns / 1ps

package deq_pkg;

   localparam int DEQ_DEPTH = 1024;
   localparam int DATA_W    = 32;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SIZE       = 3'd4,
      OP_EMPTY      = 3'd5,
      OP_FRONT      = 3'd6,
      OP_BACK       = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// ----- hw/rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words held in a single-port RAM.
// Requests arrive on the req_ stream: tuser carries the opcode, tdata the word
// to push. Results leave on the rsp_ stream: tdata carries the returned word,
// tuser the status (ok, empty, or full with the push dropped).
// A successful push gives no result. Size, empty, and every failed operation
// give one result, registered straight from decode. A successful pop or peek
// reads the RAM and gives its result from the RAM read register in ST_READ.
// Throughput is one request per cycle while req_tready is high, except that a
// successful pop or peek holds the read port in ST_READ, taking no request.
// Results pass through an output register backed by a one-entry hold register;
// while the receiver stalls, the block keeps taking requests until the hold
// register fills, and then drops req_tready until a result transfer frees it.
// Synchronous reset empties the queue (head and count to zero) and drops any
// pending result. The RAM contents are not cleared; words are only ever read
// after they were written, so no clearing pass is needed.

`include "double_ended_queue_macros.svh"

module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [deq_pkg::DATA_W-1:0]   req_tdata,  // [31:0] push_value
   input  deq_pkg::opcode_type                 req_tuser,  // [2:0] opcode
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [deq_pkg::DATA_W-1:0]   rsp_tdata,  // [31:0] result_value
   output deq_pkg::status_type                 rsp_tuser   // [1:0] status
);

   import deq_pkg::*;

   localparam int AW = $clog2(DEPTH);     // head pointer and RAM address width
   localparam int CW = $clog2(DEPTH + 1); // count width, holds DEPTH itself
   localparam int SW = AW + 1;            // head plus count before wrapping

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;

   // Output register and the hold register behind it.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     hold_valid_ff, hold_valid_in;
   logic signed [DATA_W-1:0] hold_data_ff, hold_data_in;
   status_type               hold_status_ff, hold_status_in;

   logic                     accept;
   logic                     is_full;
   logic                     is_empty;
   logic [AW-1:0]            head_dec;
   logic [AW-1:0]            head_inc;
   logic [SW-1:0]            end_sum;
   logic [SW-1:0]            end_raw;
   logic [AW-1:0]            end_idx;

   logic                     ram_we;
   logic [AW-1:0]            ram_addr;
   logic [DATA_W-1:0]        ram_rdata;

   logic                     imm_valid;
   logic signed [DATA_W-1:0] imm_data;
   status_type               imm_status;
   logic                     new_valid;
   logic signed [DATA_W-1:0] new_data;
   status_type               new_status;
   logic                     rsp_free;
   logic                     rsp_drain;

   assign req_tready = (state_ff == ST_IDLE) && !hold_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // The slot past the back for a push at the back, the back word itself otherwise.
   // A pop or peek at the back only gets here with a nonzero count.
   assign end_sum = SW'(head_ff) + SW'(count_ff);
   assign end_raw = (req_tuser == OP_PUSH_BACK) ? end_sum : end_sum - 1'b1;
   assign end_idx = (end_raw >= SW'(DEPTH)) ? AW'(end_raw - SW'(DEPTH)) : AW'(end_raw);

   // Request decode: RAM access, pointer update and any immediate result.
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      ram_we     = 1'b0;
      ram_addr   = head_ff;
      imm_valid  = 1'b0;
      imm_data   = '0;
      imm_status = STATUS_OK;

      if (state_ff == ST_READ) begin
         state_in = ST_IDLE;
      end

      case (req_tuser)
         OP_PUSH_FRONT: begin
            ram_addr = head_dec;
            if (accept) begin
               if (is_full) begin
                  imm_valid  = 1'b1;
                  imm_status = STATUS_FULL;
               end else begin
                  ram_we   = 1'b1;
                  head_in  = head_dec;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_PUSH_BACK: begin
            ram_addr = end_idx;
            if (accept) begin
               if (is_full) begin
                  imm_valid  = 1'b1;
                  imm_status = STATUS_FULL;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_SIZE: begin
            imm_valid = accept;
            imm_data  = DATA_W'(count_ff);
         end
         OP_EMPTY: begin
            imm_valid = accept;
            imm_data  = DATA_W'(is_empty);
         end
         OP_POP_FRONT, OP_FRONT: begin
            ram_addr = head_ff;
            if (accept) begin
               if (is_empty) begin
                  imm_valid  = 1'b1;
                  imm_data   = '1;
                  imm_status = STATUS_EMPTY;
               end else begin
                  state_in = ST_READ;
                  if (req_tuser == OP_POP_FRONT) begin
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         OP_POP_BACK, OP_BACK: begin
            ram_addr = end_idx;
            if (accept) begin
               if (is_empty) begin
                  imm_valid  = 1'b1;
                  imm_data   = '1;
                  imm_status = STATUS_EMPTY;
               end else begin
                  state_in = ST_READ;
                  if (req_tuser == OP_POP_BACK) begin
                     count_in = count_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            ram_addr = head_ff;
         end
      endcase
   end

   // A result comes either straight from decode or from the RAM read.
   assign new_valid  = imm_valid || (state_ff == ST_READ);
   assign new_data   = (state_ff == ST_READ) ? $signed(ram_rdata) : imm_data;
   assign new_status = (state_ff == ST_READ) ? STATUS_OK : imm_status;

   assign rsp_drain = rsp_valid_ff && rsp_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // No new result can appear while the hold register is full: requests are
   // refused then, and a read in flight was started with the hold register empty.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      hold_valid_in  = hold_valid_ff;
      hold_data_in   = hold_data_ff;
      hold_status_in = hold_status_ff;

      if (hold_valid_ff) begin
         if (rsp_drain) begin
            rsp_data_in   = hold_data_ff;
            rsp_status_in = hold_status_ff;
            hold_valid_in = 1'b0;
         end
      end else if (new_valid) begin
         if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = new_data;
            rsp_status_in = new_status;
         end else begin
            hold_valid_in  = 1'b1;
            hold_data_in   = new_data;
            hold_status_in = new_status;
         end
      end else if (rsp_drain) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
      hold_data_ff   <= hold_data_in;
      hold_status_ff <= hold_status_in;
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_tdata),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   `DEQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "count above depth")
   `DEQ_ASSERT_ALWAYS(a_hold_behind_rsp, clock, reset, !hold_valid_ff || rsp_valid_ff, "hold without output")
   `DEQ_ASSERT_NEXT(a_read_one_cycle, clock, reset, state_ff == ST_READ, state_ff == ST_IDLE && (rsp_valid_ff || hold_valid_ff), "read result lost")
   `DEQ_ASSERT_NEXT(a_push_counts, clock, reset, accept && !is_full && (req_tuser == OP_PUSH_FRONT || req_tuser == OP_PUSH_BACK), count_ff == CW'($past(count_ff) + 1'b1), "push did not count")

endmodule

// ----- hw/rtl/deq_ram.sv -----
`timescale 1ns / 1ps

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port, read-first, with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
